// ----- hw/rtl/gtg_pkg.sv -----
// ----------------------------------------------------------------------------
// gtg_pkg: shared types and constants of the go-to-goal controller
// Register indexes, widths of the arithmetic datapath and the CORDIC table.
// ----------------------------------------------------------------------------
`default_nettype none

package gtg_pkg;

    localparam int GTG_POS_WIDTH    = 24;
    localparam int GTG_CORDIC_STEPS = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_LIMIT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEADING_GATE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_TOL    = 3'd7;

    localparam logic [23:0] RST_ANGULAR_GAIN  = 24'd1677722;
    localparam logic [23:0] RST_LINEAR_GAIN   = 24'd16777;
    localparam logic [15:0] RST_LINEAR_LIMIT  = 16'd19661;
    localparam logic [15:0] RST_TURN_LIMIT    = 16'd19661;
    localparam logic [8:0]  RST_HEADING_GATE  = 9'd30;
    localparam logic [15:0] RST_ARRIVE_TOL    = 16'd10;

    // CORDIC datapath: vectors are normalized to a magnitude in [2^39, 2^40).
    localparam int CW          = 44;
    localparam int ZW          = 26;
    localparam int NORM_TOP    = 40;
    localparam int NORM_STAGES = 6;

    // Integer square root: 25 result bits from a 50-bit radicand.
    localparam int SQRT_STAGES = 25;
    localparam int SQRT_W      = 50;

    localparam logic signed [ZW-1:0] DEG180 = 26'sd11796480;

    // atan(2^-i) in degrees, signed Q.16.
    localparam logic signed [ZW-1:0] ATAN_DEG [24] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0
    };

    // Flags that travel beside the CORDIC and square root pipelines.
    typedef struct packed {
        logic arrived;
        logic passed;
        logic big;
    } t_side;

endpackage

`default_nettype wire

// ----- hw/rtl/gtg_if.sv -----
// ----------------------------------------------------------------------------
// gtg interfaces: pose, command and configuration channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface gtg_pose_if import gtg_pkg::*; #(
    parameter int POS_WIDTH = GTG_POS_WIDTH
);
    logic                        valid;
    logic                        ready;
    logic signed [POS_WIDTH-1:0] pos_x;
    logic signed [POS_WIDTH-1:0] pos_y;
    logic signed [15:0]          quat_x;
    logic signed [15:0]          quat_y;
    logic signed [15:0]          quat_z;
    logic signed [15:0]          quat_w;

    modport source (output valid, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                    output ready);
endinterface

interface gtg_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] linear_cmd;
    logic signed [16:0] angular_cmd;
    logic               arrived;

    modport source (output valid, linear_cmd, angular_cmd, arrived, input ready);
    modport sink   (input valid, linear_cmd, angular_cmd, arrived, output ready);
endinterface

interface gtg_cfg_if import gtg_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/gtg_cordic.sv -----
// ----------------------------------------------------------------------------
// gtg_cordic: pipelined atan2 in degrees
// Normalizer, half-plane fold and one CORDIC vectoring step per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gtg_cordic import gtg_pkg::*; #(
    parameter int CORDIC_STEPS = GTG_CORDIC_STEPS,
    parameter int PAD          = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    output logic signed [ZW-1:0] o_z
);

    logic signed [CW-1:0] r_nx [NORM_STAGES];
    logic signed [CW-1:0] r_ny [NORM_STAGES];
    logic signed [CW-1:0] r_px;
    logic signed [CW-1:0] r_py;
    logic signed [ZW-1:0] r_pz;
    logic signed [CW-1:0] r_cx [CORDIC_STEPS];
    logic signed [CW-1:0] r_cy [CORDIC_STEPS];
    logic signed [ZW-1:0] r_cz [CORDIC_STEPS];

    // Binary search for the left shift that brings the larger magnitude
    // into [2^39, 2^40); each stage tries one power of two.
    for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
        localparam int SH = 32 >> k;
        logic signed [CW-1:0] w_x, w_y, w_ax, w_ay;
        if (k == 0) begin : g_first
            assign w_x = i_x;
            assign w_y = i_y;
        end else begin : g_next
            assign w_x = r_nx[k-1];
            assign w_y = r_ny[k-1];
        end
        assign w_ax = w_x[CW-1] ? -w_x : w_x;
        assign w_ay = w_y[CW-1] ? -w_y : w_y;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ((w_ax >> (NORM_TOP - SH)) == '0 && (w_ay >> (NORM_TOP - SH)) == '0) begin
                    r_nx[k] <= w_x <<< SH;
                    r_ny[k] <= w_y <<< SH;
                end else begin
                    r_nx[k] <= w_x;
                    r_ny[k] <= w_y;
                end
            end
        end
    end

    // Fold the left half plane onto the right one.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_nx[NORM_STAGES-1][CW-1]) begin
                r_pz <= r_ny[NORM_STAGES-1][CW-1] ? -DEG180 : DEG180;
                r_px <= -r_nx[NORM_STAGES-1];
                r_py <= -r_ny[NORM_STAGES-1];
            end else begin
                r_pz <= '0;
                r_px <= r_nx[NORM_STAGES-1];
                r_py <= r_ny[NORM_STAGES-1];
            end
        end
    end

    // Once y reaches zero the vector is left alone for the remaining steps.
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        logic signed [CW-1:0] w_x, w_y;
        logic signed [ZW-1:0] w_z;
        if (k == 0) begin : g_first
            assign w_x = r_px;
            assign w_y = r_py;
            assign w_z = r_pz;
        end else begin : g_next
            assign w_x = r_cx[k-1];
            assign w_y = r_cy[k-1];
            assign w_z = r_cz[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_y[CW-1] && w_y != '0) begin
                    r_cx[k] <= w_x + (w_y >>> k);
                    r_cy[k] <= w_y - (w_x >>> k);
                    r_cz[k] <= w_z + ATAN_DEG[k];
                end else if (w_y[CW-1]) begin
                    r_cx[k] <= w_x - (w_y >>> k);
                    r_cy[k] <= w_y + (w_x >>> k);
                    r_cz[k] <= w_z - ATAN_DEG[k];
                end else begin
                    r_cx[k] <= w_x;
                    r_cy[k] <= w_y;
                    r_cz[k] <= w_z;
                end
            end
        end
    end

    if (PAD > 0) begin : g_pad
        logic signed [ZW-1:0] r_dz [PAD];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dz[0] <= r_cz[CORDIC_STEPS-1];
                for (int j = 1; j < PAD; j++) begin
                    r_dz[j] <= r_dz[j-1];
                end
            end
        end
        assign o_z = r_dz[PAD-1];
    end else begin : g_nopad
        assign o_z = r_cz[CORDIC_STEPS-1];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/go_to_goal_velocity_controller.sv -----
// ----------------------------------------------------------------------------
// go_to_goal_velocity_controller: proportional go-to-goal velocity controller
// Turns pose words into clamped linear and angular velocity commands.
// ----------------------------------------------------------------------------
// Each pose word (position in mm, orientation quaternion in Q1.15) yields one
// command word. The yaw and the bearing to the target come from two pipelined
// CORDIC atan2 units in Q.16 degrees; the distance comes from a pipelined
// integer square root with one result bit per stage. The block takes one pose
// word every cycle while the output is not stalled. Both pipes are padded to
// MID stages, the longer of the CORDIC pipe (CORDIC_STEPS + 7 stages) and
// the square root pipe (25 stages), so that the two results meet. The
// whole pipeline advances together; while a finished command waits on a low
// ready the pipeline holds and input ready is low. The start pose used for
// the passed-the-goal test is captured from the first pose word after reset.
// Configuration writes are always accepted and should only be made while no
// pose word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module go_to_goal_velocity_controller import gtg_pkg::*; #(
    parameter int POS_WIDTH    = GTG_POS_WIDTH,
    parameter int CORDIC_STEPS = GTG_CORDIC_STEPS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gtg_cfg_if.sink    i_cfg,
    gtg_pose_if.sink   i_pose,
    gtg_cmd_if.source  o_cmd
);

    // Width of a target-minus-position difference.
    localparam int DW         = ((POS_WIDTH > 24) ? POS_WIDTH : 24) + 1;
    localparam int HW         = DW - 17;
    localparam int PPW        = 2 * DW + 2;
    localparam int CORDIC_LAT = NORM_STAGES + 1 + CORDIC_STEPS;
    localparam int MID        = (CORDIC_LAT > SQRT_STAGES) ? CORDIC_LAT : SQRT_STAGES;
    localparam int PAD_C      = MID - CORDIC_LAT;
    localparam int PAD_S      = MID - SQRT_STAGES;

    localparam logic signed [CW-1:0] ONE_Q30  = CW'(64'sd1073741824);
    localparam logic        [24:0]   DIST_CAP = 25'd16777216;

    // ---------------- configuration registers ----------------
    logic signed [23:0] r_target_x, r_target_y;
    logic [23:0]        r_angular_gain, r_linear_gain;
    logic [15:0]        r_linear_limit, r_turn_limit, r_arrive_tol;
    logic [8:0]         r_heading_gate;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x      <= '0;
            r_target_y      <= '0;
            r_angular_gain  <= RST_ANGULAR_GAIN;
            r_linear_gain   <= RST_LINEAR_GAIN;
            r_linear_limit  <= RST_LINEAR_LIMIT;
            r_turn_limit    <= RST_TURN_LIMIT;
            r_heading_gate  <= RST_HEADING_GATE;
            r_arrive_tol    <= RST_ARRIVE_TOL;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                REG_TARGET_X:      r_target_x      <= i_cfg.wr_data[23:0];
                REG_TARGET_Y:      r_target_y      <= i_cfg.wr_data[23:0];
                REG_ANGULAR_GAIN:  r_angular_gain  <= i_cfg.wr_data[23:0];
                REG_LINEAR_GAIN:   r_linear_gain   <= i_cfg.wr_data[23:0];
                REG_LINEAR_LIMIT:  r_linear_limit  <= i_cfg.wr_data[15:0];
                REG_TURN_LIMIT:    r_turn_limit    <= i_cfg.wr_data[15:0];
                REG_HEADING_GATE:  r_heading_gate  <= i_cfg.wr_data[8:0];
                REG_ARRIVE_TOL:    r_arrive_tol    <= i_cfg.wr_data[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // One enable for every stage: the pipeline moves whenever the output
    // register is empty or its word is being taken.
    logic w_en, w_accept;
    logic r_va, r_vb, r_ve1, r_ve2, r_vf;
    logic r_mv [MID];

    assign w_en         = !r_vf || o_cmd.ready;
    assign i_pose.ready = w_en;
    assign w_accept     = i_pose.valid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va  <= 1'b0;
            r_vb  <= 1'b0;
            r_ve1 <= 1'b0;
            r_ve2 <= 1'b0;
            r_vf  <= 1'b0;
            for (int j = 0; j < MID; j++) begin
                r_mv[j] <= 1'b0;
            end
        end else if (w_en) begin
            r_va    <= i_pose.valid;
            r_vb    <= r_va;
            r_mv[0] <= r_vb;
            for (int j = 1; j < MID; j++) begin
                r_mv[j] <= r_mv[j-1];
            end
            r_ve1 <= r_mv[MID-1];
            r_ve2 <= r_ve1;
            r_vf  <= r_ve2;
        end
    end

    // ---------------- start pose ----------------
    logic                        r_start_taken;
    logic signed [POS_WIDTH-1:0] r_start_x, r_start_y;
    logic signed [POS_WIDTH-1:0] w_sx, w_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_taken <= 1'b0;
        end else if (w_accept) begin
            r_start_taken <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !r_start_taken) begin
            r_start_x <= i_pose.pos_x;
            r_start_y <= i_pose.pos_y;
        end
    end

    // The first pose is its own start pose.
    assign w_sx = r_start_taken ? r_start_x : i_pose.pos_x;
    assign w_sy = r_start_taken ? r_start_y : i_pose.pos_y;

    // ---------------- stage A: differences ----------------
    logic signed [DW-1:0] r_a_dx, r_a_dy, r_a_sdx, r_a_sdy;
    logic signed [15:0]   r_a_qx, r_a_qy, r_a_qz, r_a_qw;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_dx  <= DW'(r_target_x) - DW'(i_pose.pos_x);
            r_a_dy  <= DW'(r_target_y) - DW'(i_pose.pos_y);
            r_a_sdx <= DW'(r_target_x) - DW'(w_sx);
            r_a_sdy <= DW'(r_target_y) - DW'(w_sy);
            r_a_qx  <= i_pose.quat_x;
            r_a_qy  <= i_pose.quat_y;
            r_a_qz  <= i_pose.quat_z;
            r_a_qw  <= i_pose.quat_w;
        end
    end

    // ---------------- stage B: products ----------------
    logic [DW-1:0]          w_ax, w_ay;
    logic signed [HW-1:0]   w_sdx_h, w_sdy_h;
    logic signed [17:0]     w_sdx_l, w_sdy_l;
    logic signed [31:0]     r_b_qwz, r_b_qxy, r_b_qyy, r_b_qzz;
    logic [47:0]            r_b_sqx, r_b_sqy;
    logic                   r_b_big, r_b_arr;
    logic signed [DW-1:0]   r_b_dx, r_b_dy;
    logic signed [HW+DW-1:0] r_b_ph, r_b_qh;
    logic signed [DW+17:0]  r_b_pl, r_b_ql;

    assign w_ax    = r_a_dx[DW-1] ? DW'(-r_a_dx) : DW'(r_a_dx);
    assign w_ay    = r_a_dy[DW-1] ? DW'(-r_a_dy) : DW'(r_a_dy);
    // Split the start-to-target vector so the exact passed test stays within
    // ordinary multiplier widths: a = ah * 2^17 + al.
    assign w_sdx_h = r_a_sdx[DW-1:17];
    assign w_sdy_h = r_a_sdy[DW-1:17];
    assign w_sdx_l = {1'b0, r_a_sdx[16:0]};
    assign w_sdy_l = {1'b0, r_a_sdy[16:0]};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_qwz <= r_a_qw * r_a_qz;
            r_b_qxy <= r_a_qx * r_a_qy;
            r_b_qyy <= r_a_qy * r_a_qy;
            r_b_qzz <= r_a_qz * r_a_qz;
            r_b_sqx <= w_ax[23:0] * w_ax[23:0];
            r_b_sqy <= w_ay[23:0] * w_ay[23:0];
            r_b_big <= (w_ax[DW-1:24] != '0) || (w_ay[DW-1:24] != '0);
            r_b_arr <= (w_ax <= DW'(r_arrive_tol)) || (w_ay <= DW'(r_arrive_tol));
            r_b_dx  <= r_a_dx;
            r_b_dy  <= r_a_dy;
            r_b_ph  <= w_sdx_h * r_a_dx;
            r_b_qh  <= w_sdy_h * r_a_dy;
            r_b_pl  <= w_sdx_l * r_a_dx;
            r_b_ql  <= w_sdy_l * r_a_dy;
        end
    end

    // ---------------- middle: CORDIC, square root, side flags ----------------
    logic signed [CW-1:0]  w_t3, w_t4;
    logic signed [PPW-1:0] w_psum;
    t_side                 w_side0;
    t_side                 r_ms [MID];
    logic signed [ZW-1:0]  w_yaw, w_bear;

    // yaw = atan2(2(wz + xy), 1 - 2(y^2 + z^2)) with 1.0 at 2^30.
    assign w_t3 = (CW'(r_b_qwz) + CW'(r_b_qxy)) <<< 1;
    assign w_t4 = ONE_Q30 - ((CW'(r_b_qyy) + CW'(r_b_qzz)) <<< 1);

    // Sign of (tx - sx)(tx - x) + (ty - sy)(ty - y), exact.
    assign w_psum = ((PPW'(r_b_ph) + PPW'(r_b_qh)) <<< 17) + PPW'(r_b_pl) + PPW'(r_b_ql);

    assign w_side0.arrived = r_b_arr;
    assign w_side0.passed  = w_psum[PPW-1];
    assign w_side0.big     = r_b_big;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ms[0] <= w_side0;
            for (int j = 1; j < MID; j++) begin
                r_ms[j] <= r_ms[j-1];
            end
        end
    end

    gtg_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .PAD          (PAD_C)
    ) u_yaw (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (w_t4),
        .i_y   (w_t3),
        .o_z   (w_yaw)
    );

    gtg_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .PAD          (PAD_C)
    ) u_bearing (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (CW'(r_b_dx)),
        .i_y   (CW'(r_b_dy)),
        .o_z   (w_bear)
    );

    // Digit-by-digit square root of dx^2 + dy^2, one result bit per stage.
    logic [SQRT_W-1:0] r_sv [SQRT_STAGES];
    logic [SQRT_W-1:0] r_sr [SQRT_STAGES];
    logic [24:0]       w_root;

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
        localparam logic [SQRT_W-1:0] SQ_BIT = SQRT_W'(1) << (2 * (SQRT_STAGES - 1 - k));
        logic [SQRT_W-1:0] w_v, w_r, w_t;
        if (k == 0) begin : g_first
            assign w_v = SQRT_W'(r_b_sqx) + SQRT_W'(r_b_sqy);
            assign w_r = '0;
        end else begin : g_next
            assign w_v = r_sv[k-1];
            assign w_r = r_sr[k-1];
        end
        assign w_t = w_r + SQ_BIT;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (w_v >= w_t) begin
                    r_sv[k] <= w_v - w_t;
                    r_sr[k] <= (w_r >> 1) + SQ_BIT;
                end else begin
                    r_sv[k] <= w_v;
                    r_sr[k] <= w_r >> 1;
                end
            end
        end
    end

    if (PAD_S > 0) begin : g_sqrt_pad
        logic [24:0] r_dd [PAD_S];
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dd[0] <= r_sr[SQRT_STAGES-1][24:0];
                for (int j = 1; j < PAD_S; j++) begin
                    r_dd[j] <= r_dd[j-1];
                end
            end
        end
        assign w_root = r_dd[PAD_S-1];
    end else begin : g_sqrt_nopad
        assign w_root = r_sr[SQRT_STAGES-1][24:0];
    end

    // ---------------- stage E1: heading error, distance ----------------
    logic signed [ZW:0] w_err;
    logic [ZW-1:0]      w_aerr;
    logic               r_e1_neg, r_e1_gated;
    logic [ZW-1:0]      r_e1_aerr;
    logic [24:0]        r_e1_dist;
    t_side              r_e1_side;

    // The heading error is not wrapped into +-180 degrees.
    assign w_err  = (ZW+1)'(w_bear) - (ZW+1)'(w_yaw);
    assign w_aerr = w_err[ZW] ? ZW'(-w_err) : ZW'(w_err);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e1_neg   <= w_err[ZW];
            r_e1_aerr  <= w_aerr;
            r_e1_gated <= w_aerr > ZW'({r_heading_gate, 16'h0000});
            if (r_ms[MID-1].big || w_root > DIST_CAP) begin
                r_e1_dist <= DIST_CAP;
            end else begin
                r_e1_dist <= w_root;
            end
            r_e1_side <= r_ms[MID-1];
        end
    end

    // ---------------- stage E2: gain products ----------------
    logic [ZW+23:0] r_e2_amul;
    logic [48:0]    r_e2_lmul;
    logic           r_e2_neg, r_e2_gated;
    t_side          r_e2_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e2_amul  <= r_e1_aerr * r_angular_gain;
            r_e2_lmul  <= r_e1_dist * r_linear_gain;
            r_e2_neg   <= r_e1_neg;
            r_e2_gated <= r_e1_gated;
            r_e2_side  <= r_e1_side;
        end
    end

    // ---------------- stage F: clamp, sign, output register ----------------
    logic [ZW-1:0]      w_amag;
    logic [40:0]        w_lmag;
    logic [15:0]        w_aclamp, w_lclamp;
    logic signed [16:0] w_ang, w_lin, w_lin_gated;
    logic signed [16:0] r_f_lin, r_f_ang;
    logic               r_f_arr;

    assign w_amag      = r_e2_amul[ZW+23:24];
    assign w_lmag      = r_e2_lmul[48:8];
    assign w_aclamp    = (w_amag > ZW'(r_turn_limit)) ? r_turn_limit : w_amag[15:0];
    assign w_lclamp    = (w_lmag > 41'(r_linear_limit)) ? r_linear_limit : w_lmag[15:0];
    assign w_ang       = r_e2_neg ? -$signed({1'b0, w_aclamp}) : $signed({1'b0, w_aclamp});
    assign w_lin_gated = r_e2_gated ? 17'sd0 : $signed({1'b0, w_lclamp});
    assign w_lin       = r_e2_side.passed ? -w_lin_gated : w_lin_gated;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_arr <= r_e2_side.arrived;
            if (r_e2_side.arrived) begin
                r_f_lin <= '0;
                r_f_ang <= '0;
            end else begin
                r_f_lin <= w_lin;
                r_f_ang <= w_ang;
            end
        end
    end

    assign o_cmd.valid       = r_vf;
    assign o_cmd.linear_cmd  = r_f_lin;
    assign o_cmd.angular_cmd = r_f_ang;
    assign o_cmd.arrived     = r_f_arr;

endmodule

`default_nettype wire

// ----- hw/rtl/gtg_checker.sv -----
// ----------------------------------------------------------------------------
// gtg_checker: port-level checks of the go-to-goal controller
// Watches the pose and command channels and the reset behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module gtg_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_pose_ready,
    input logic              i_cmd_valid,
    input logic              i_cmd_ready,
    input logic signed [16:0] i_linear_cmd,
    input logic signed [16:0] i_angular_cmd,
    input logic              i_arrived
);

    // A command word that waits keeps its value.
    a_cmd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && !i_cmd_ready |=> i_cmd_valid && $stable(i_linear_cmd)
            && $stable(i_angular_cmd) && $stable(i_arrived))
        else $error("command word changed while stalled");

    // A stalled output freezes the whole pipeline, so no pose word may enter.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && !i_cmd_ready |-> !i_pose_ready)
        else $error("pose accepted while output stalled");

    // Arrival suppresses both commands.
    a_arrived_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_arrived |-> i_linear_cmd == 17'sd0 && i_angular_cmd == 17'sd0)
        else $error("nonzero command while arrived");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_cmd_valid)
        else $error("command valid after reset");

endmodule

bind go_to_goal_velocity_controller gtg_checker u_gtg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_pose_ready  (i_pose.ready),
    .i_cmd_valid   (o_cmd.valid),
    .i_cmd_ready   (o_cmd.ready),
    .i_linear_cmd  (o_cmd.linear_cmd),
    .i_angular_cmd (o_cmd.angular_cmd),
    .i_arrived     (o_cmd.arrived)
);

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench of the go-to-goal velocity controller
// Drives pose words through several register settings, predicts each command
// word in a scoreboard and compares every field.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
    logic signed [16:0] linear_cmd;
    logic signed [16:0] angular_cmd;
    logic               arrived;
} t_cmd_word;

class gtg_scoreboard;
    // Register file and start pose as the block holds them.
    longint          target_x, target_y;
    longint unsigned angular_gain, linear_gain, linear_limit, turn_limit;
    longint unsigned heading_gate, arrive_tol;
    bit              start_taken;
    longint          start_x, start_y;
    t_cmd_word       expected_cmds[$];
    int              mismatches;
    int              unexpected;

    function new();
        target_x      = 0;
        target_y      = 0;
        angular_gain  = gtg_pkg::RST_ANGULAR_GAIN;
        linear_gain   = gtg_pkg::RST_LINEAR_GAIN;
        linear_limit  = gtg_pkg::RST_LINEAR_LIMIT;
        turn_limit    = gtg_pkg::RST_TURN_LIMIT;
        heading_gate  = gtg_pkg::RST_HEADING_GATE;
        arrive_tol    = gtg_pkg::RST_ARRIVE_TOL;
        start_taken   = 0;
        mismatches    = 0;
        unexpected    = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] data);
        case (idx)
            gtg_pkg::REG_TARGET_X:      target_x = longint'($signed(data));
            gtg_pkg::REG_TARGET_Y:      target_y = longint'($signed(data));
            gtg_pkg::REG_ANGULAR_GAIN:  angular_gain = data;
            gtg_pkg::REG_LINEAR_GAIN:   linear_gain = data;
            gtg_pkg::REG_LINEAR_LIMIT:  linear_limit = data[15:0];
            gtg_pkg::REG_TURN_LIMIT:    turn_limit = data[15:0];
            gtg_pkg::REG_HEADING_GATE:  heading_gate = data[8:0];
            gtg_pkg::REG_ARRIVE_TOL:    arrive_tol = data[15:0];
            default: ;
        endcase
    endfunction

    // Vectoring CORDIC angle in Q.16 degrees, after scaling the vector up.
    function longint bearing_q16(longint y, longint x);
        longint z;
        longint nx;
        z = 0;
        if (x == 0 && y == 0) return 0;
        while ((x < 0 ? -x : x) < (64'sd1 << 39) && (y < 0 ? -y : y) < (64'sd1 << 39)) begin
            x = x * 2;
            y = y * 2;
        end
        if (x < 0) begin
            z = (y >= 0) ? longint'(gtg_pkg::DEG180) : -longint'(gtg_pkg::DEG180);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < gtg_pkg::GTG_CORDIC_STEPS && i < 24; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += longint'(gtg_pkg::ATAN_DEG[i]);
            end else if (y < 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= longint'(gtg_pkg::ATAN_DEG[i]);
            end else begin
                break;
            end
            x = nx;
        end
        return z;
    endfunction

    function longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function void note_pose(logic signed [23:0] px_in, logic signed [23:0] py_in,
                            logic signed [15:0] qx_in, logic signed [15:0] qy_in,
                            logic signed [15:0] qz_in, logic signed [15:0] qw_in);
        longint          px, py, qx, qy, qz, qw;
        longint          yaw, dx, dy, err, aerr, lin, ang;
        longint unsigned ax, ay, dist_mm, mag;
        t_cmd_word       c;
        px = px_in; py = py_in;
        qx = qx_in; qy = qy_in; qz = qz_in; qw = qw_in;
        yaw = bearing_q16(2 * (qw * qz + qx * qy), (64'sd1 << 30) - 2 * (qy * qy + qz * qz));
        if (!start_taken) begin
            start_x = px;
            start_y = py;
            start_taken = 1;
        end
        dx   = target_x - px;
        dy   = target_y - py;
        err  = bearing_q16(dy, dx) - yaw;
        aerr = err < 0 ? -err : err;
        mag  = (angular_gain * longint'(aerr)) >> 24;
        if (mag > turn_limit) mag = turn_limit;
        ang = err < 0 ? -longint'(mag) : longint'(mag);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        if (ax >= (64'd1 << 24) || ay >= (64'd1 << 24)) dist_mm = 64'd1 << 24;
        else dist_mm = floor_root(ax * ax + ay * ay);
        if (dist_mm > (64'd1 << 24)) dist_mm = 64'd1 << 24;
        mag = (linear_gain * dist_mm) >> 8;
        if (mag > linear_limit) mag = linear_limit;
        lin = mag;
        if (aerr > longint'(heading_gate << 16)) lin = 0;
        // Behind the goal as seen from the start pose: drive backward.
        if ((target_x - start_x) * dx + (target_y - start_y) * dy < 0) lin = -lin;
        c.arrived = (ax <= arrive_tol) || (ay <= arrive_tol);
        if (c.arrived) begin
            lin = 0;
            ang = 0;
        end
        c.linear_cmd  = lin[16:0];
        c.angular_cmd = ang[16:0];
        expected_cmds.push_back(c);
    endfunction

    function void check_cmd(logic signed [16:0] lin, logic signed [16:0] ang, logic arr);
        t_cmd_word e;
        if (expected_cmds.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= 10)
                $display("command word with none expected: lin=%0d ang=%0d arr=%b",
                         lin, ang, arr);
            return;
        end
        e = expected_cmds.pop_front();
        if (lin !== e.linear_cmd || ang !== e.angular_cmd || arr !== e.arrived) begin
            mismatches++;
            if (mismatches + unexpected <= 10)
                $display("mismatch: exp lin=%0d ang=%0d arr=%b, got lin=%0d ang=%0d arr=%b",
                         e.linear_cmd, e.angular_cmd, e.arrived, lin, ang, arr);
        end
    endfunction

    function int pending();
        return expected_cmds.size();
    endfunction
endclass

module tb;
    import gtg_pkg::*;

    // Pipeline depth of the block with default parameters, plus margin.
    localparam int DRAIN_CYCLES = 45;

    logic i_clk;
    logic i_rst_n;
    bit   calm;    // when set, neither side idles

    gtg_pose_if pose_if ();
    gtg_cmd_if  cmd_if ();
    gtg_cfg_if  cfg_if ();

    gtg_scoreboard sb;

    go_to_goal_velocity_controller dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_pose  (pose_if),
        .o_cmd   (cmd_if)
    );

    always #5 i_clk = ~i_clk;

    // The command sink stalls at random, with a probability of 13 percent, unless calm is set.
    always @(negedge i_clk) begin
        cmd_if.ready <= calm || ($urandom_range(99) >= 13);
    end

    // Every accepted word is seen here at the rising edge. The pose is noted
    // before the command is checked; the pipeline keeps the two far apart.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                sb.write_reg(cfg_if.reg_index, cfg_if.wr_data);
            if (pose_if.valid && pose_if.ready)
                sb.note_pose(pose_if.pos_x, pose_if.pos_y, pose_if.quat_x,
                             pose_if.quat_y, pose_if.quat_z, pose_if.quat_w);
            if (cmd_if.valid && cmd_if.ready)
                sb.check_cmd(cmd_if.linear_cmd, cmd_if.angular_cmd, cmd_if.arrived);
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #8000000;
        $display("** go_to_goal_velocity_controller: FAILED **");
        $finish;
    end

    // Waits until every command word has come back, then lets the pipe drain.
    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_if.valid     = 1'b1;
        cfg_if.reg_index = idx;
        cfg_if.wr_data   = data;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic write_all(logic [23:0] tx, logic [23:0] ty, logic [23:0] ag,
                             logic [23:0] lg, logic [23:0] ll, logic [23:0] al,
                             logic [23:0] gate, logic [23:0] tol);
        write_reg(REG_TARGET_X, tx);
        write_reg(REG_TARGET_Y, ty);
        write_reg(REG_ANGULAR_GAIN, ag);
        write_reg(REG_LINEAR_GAIN, lg);
        write_reg(REG_LINEAR_LIMIT, ll);
        write_reg(REG_TURN_LIMIT, al);
        write_reg(REG_HEADING_GATE, gate);
        write_reg(REG_ARRIVE_TOL, tol);
    endtask

    // Presents one pose word and returns once it has been accepted. Valid is
    // left high so that back-to-back words follow without a gap when calm is set.
    task automatic send_pose(logic signed [23:0] px, logic signed [23:0] py,
                             logic signed [15:0] qx, logic signed [15:0] qy,
                             logic signed [15:0] qz, logic signed [15:0] qw);
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 15) begin
            pose_if.valid = 1'b0;
            @(negedge i_clk);
        end
        pose_if.valid  = 1'b1;
        pose_if.pos_x  = px;
        pose_if.pos_y  = py;
        pose_if.quat_x = qx;
        pose_if.quat_y = qy;
        pose_if.quat_z = qz;
        pose_if.quat_w = qw;
        do @(posedge i_clk); while (!pose_if.ready);
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        pose_if.valid = 1'b0;
    endtask

    // A random pose around the current target. Most poses lie close enough to
    // steer, some lie within the arrival band and some lie anywhere at all.
    // Most orientations are close to yaw-only, the rest are arbitrary quaternions.
    task automatic random_pose();
        logic signed [23:0] px, py;
        logic signed [15:0] qx, qy, qz, qw;
        int sel;
        sel = $urandom_range(99);
        if (sel < 15) begin
            px = 24'(sb.target_x + $signed($urandom_range(40)) - 20);
            py = 24'(sb.target_y + $signed($urandom_range(4000)) - 2000);
        end else if (sel < 60) begin
            px = 24'(sb.target_x + $signed($urandom_range(4000)) - 2000);
            py = 24'(sb.target_y + $signed($urandom_range(4000)) - 2000);
        end else if (sel < 80) begin
            px = 24'(sb.target_x + $signed($urandom_range(400000)) - 200000);
            py = 24'(sb.target_y + $signed($urandom_range(400000)) - 200000);
        end else begin
            px = 24'($urandom);
            py = 24'($urandom);
        end
        qz = 16'($urandom);
        qw = 16'($urandom);
        if ($urandom_range(99) < 70) begin
            qx = 16'($signed($urandom_range(200)) - 100);
            qy = 16'($signed($urandom_range(200)) - 100);
        end else begin
            qx = 16'($urandom);
            qy = 16'($urandom);
        end
        send_pose(px, py, qx, qy, qz, qw);
    endtask

    task automatic random_phase(int count, bit pause_midway);
        for (int n = 0; n < count; n++) begin
            random_pose();
            if (pause_midway && n == count / 2) begin
                end_burst();
                while (sb.pending() != 0) @(posedge i_clk);
            end
        end
        end_burst();
        wait_idle();
    endtask

    initial begin
        sb = new();
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        calm = 1'b0;
        pose_if.valid = 1'b0;
        pose_if.pos_x = '0;
        pose_if.pos_y = '0;
        pose_if.quat_x = '0;
        pose_if.quat_y = '0;
        pose_if.quat_z = '0;
        pose_if.quat_w = '0;
        cfg_if.valid = 1'b0;
        cfg_if.reg_index = '0;
        cfg_if.wr_data = '0;
        cmd_if.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words under the reset settings with the goal at the
        // origin. The first pose fixes the start point for the whole run.
        send_pose(-24'sd1000, -24'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'sd32767);
        // Past the goal along the start line; the heading gate zeroes the linear command.
        send_pose(24'sd500, 24'sd600, 16'sd0, 16'sd0, 16'sd11585, 16'sd11585);
        // Quaternion whose yaw vector is zero.
        send_pose(24'sd300, -24'sd400, -16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
        // Yaw along the negative x axis.
        send_pose(24'sd200, 24'sd900, 16'sd0, 16'sd32767, 16'sd0, 16'sd0);
        // Goal straight along negative x from the robot, and exactly at it.
        send_pose(24'sd5000, 24'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767);
        send_pose(24'sd0, 24'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767);
        // Field extremes and a degenerate all-zero quaternion.
        send_pose(24'sh7FFFFF, 24'sh7FFFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_pose(24'sh800000, 24'sh800000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_pose(24'sh7FFFFF, 24'sh800000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_pose(24'sd15, 24'sd3000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_pose(-24'sd10, 24'sd3000, 16'sd0, 16'sd0, 16'sh8000, 16'sd0);
        send_pose(24'sd2000, -24'sd11, 16'sd0, 16'sd0, 16'sd32767, 16'sd0);
        end_burst();
        wait_idle();

        // Largest gains and limits, widest gate, far corner goal, no
        // tolerance. This phase runs with no idling on either side.
        calm = 1'b1;
        write_all(24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'hFFFFFF,
                  24'h00FFFF, 24'h00FFFF, 24'd360, 24'd0);
        send_pose(24'sh800000, 24'sh7FFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd32767);
        random_phase(300, 1'b0);
        calm = 1'b0;

        // Zero gains and limits, closed gate, huge tolerance.
        write_all(24'h000000, 24'h000000, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'h00FFFF);
        random_phase(150, 1'b0);

        // Reset gains, limits and tolerance with the gate at its widest code, and a pause midway.
        write_all(24'd1000, 24'(-24'sd2500), RST_ANGULAR_GAIN, RST_LINEAR_GAIN,
                  24'(RST_LINEAR_LIMIT), 24'(RST_TURN_LIMIT), 24'd511,
                  24'(RST_ARRIVE_TOL));
        random_phase(350, 1'b1);

        // Random settings for the rest of the run.
        for (int p = 0; p < 4; p++) begin
            write_all(24'($signed($urandom_range(8000000)) - 4000000),
                      24'($signed($urandom_range(8000000)) - 4000000),
                      24'($urandom_range(24'hFFFFFF)), 24'($urandom_range(24'h00FFFF)),
                      24'($urandom_range(16'hFFFF)), 24'($urandom_range(16'hFFFF)),
                      24'($urandom_range(360)), 24'($urandom_range(30)));
            random_phase(225, 1'b0);
        end

        if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending() == 0) begin
            $display("** go_to_goal_velocity_controller: PASSED **");
        end else begin
            $display("** go_to_goal_velocity_controller: FAILED **");
        end
        $finish;
    end
endmodule

`default_nettype wire
